// ----- rtl/aspd_pkg.sv -----
package aspd_pkg;

   localparam int unsigned CsrIndexBits = 3;
   localparam int unsigned CsrDataBits  = 32;
   localparam int unsigned GainBits     = 16;
   localparam int unsigned ThrBits      = 16;
   localparam int unsigned TimeBits     = 32;
   localparam int unsigned MinSample    = 100;

   localparam logic [GainBits-1:0] GainFastReset = 16'd32768;
   localparam logic [GainBits-1:0] GainSlowReset = 16'd6554;
   localparam logic [TimeBits-1:0] TimeoutReset  = 32'd1;

   typedef enum logic [CsrIndexBits-1:0] {
      CSR_GAIN_FAST      = 3'd0,
      CSR_GAIN_SLOW      = 3'd1,
      CSR_DISTANCE_MIN   = 3'd2,
      CSR_TRIGGER_MARGIN = 3'd3,
      CSR_RISE_TIMEOUT   = 3'd4,
      CSR_FALL_TIMEOUT   = 3'd5,
      CSR_FREEZE_RESULT  = 3'd6
   } csr_index_type;

   typedef struct packed {
      logic [ThrBits-1:0]  distance_min;
      logic [ThrBits-1:0]  trigger_margin;
      logic [TimeBits-1:0] rise_timeout;
      logic [TimeBits-1:0] fall_timeout;
      logic                freeze;
   } det_cfg_type;

   typedef struct packed {
      logic                valid;
      logic                last;
      logic [TimeBits-1:0] now_ms;
   } stage_ctrl_type;

endpackage

// ----- rtl/adaptive_smoothing_presence_detector.sv -----
// Channel    Direction  Handshake             Payload
// req        in         req_valid/req_stall   req_sample, req_last_in_block, req_now_ms
// rsp        out        rsp_valid/rsp_stall   rsp_level, rsp_detected
// csr        in         csr_wr_en             csr_index, csr_wdata
//
// One sample is taken every cycle unless req_stall is high; the filter multiply-accumulate
// finishes in the cycle of the transfer, and the detector then works from the stage register.
// The block result is registered when the detector takes the block's last sample.
// Synchronous reset restores the register defaults and clears filter and detector.
// A stalled result holds; samples keep flowing until a block end reaches the stage
// register behind it.
module adaptive_smoothing_presence_detector import aspd_pkg::*; #(
   parameter int unsigned SAMPLE_BITS    = 12,
   parameter int unsigned GAIN_FRAC_BITS = 16
) (
   input  logic                    clock,
   input  logic                    reset,
   input  logic                    req_valid,
   output logic                    req_stall,
   input  logic [SAMPLE_BITS-1:0]  req_sample,
   input  logic                    req_last_in_block,
   input  logic [TimeBits-1:0]     req_now_ms,
   output logic                    rsp_valid,
   input  logic                    rsp_stall,
   output logic [SAMPLE_BITS-1:0]  rsp_level,
   output logic                    rsp_detected,
   input  logic                    csr_wr_en,
   input  logic [CsrIndexBits-1:0] csr_index,
   input  logic [CsrDataBits-1:0]  csr_wdata
);

   logic [GainBits-1:0] gain_fast_ff, gain_fast_in;
   logic [GainBits-1:0] gain_slow_ff, gain_slow_in;
   det_cfg_type         cfg_ff, cfg_in;

   stage_ctrl_type         stage_ctrl;
   logic [SAMPLE_BITS-1:0] stage_level;
   logic                   stage_take;

   always_comb begin
      gain_fast_in = gain_fast_ff;
      gain_slow_in = gain_slow_ff;
      cfg_in       = cfg_ff;
      if (csr_wr_en) begin
         unique case (csr_index_type'(csr_index))
            CSR_GAIN_FAST:      gain_fast_in          = csr_wdata[GainBits-1:0];
            CSR_GAIN_SLOW:      gain_slow_in          = csr_wdata[GainBits-1:0];
            CSR_DISTANCE_MIN:   cfg_in.distance_min   = csr_wdata[ThrBits-1:0];
            CSR_TRIGGER_MARGIN: cfg_in.trigger_margin = csr_wdata[ThrBits-1:0];
            CSR_RISE_TIMEOUT:   cfg_in.rise_timeout   = csr_wdata[TimeBits-1:0];
            CSR_FALL_TIMEOUT:   cfg_in.fall_timeout   = csr_wdata[TimeBits-1:0];
            CSR_FREEZE_RESULT:  cfg_in.freeze         = csr_wdata[0];
            default: begin
            end
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         gain_fast_ff          <= GainFastReset;
         gain_slow_ff          <= GainSlowReset;
         cfg_ff.distance_min   <= '0;
         cfg_ff.trigger_margin <= '0;
         cfg_ff.rise_timeout   <= TimeoutReset;
         cfg_ff.fall_timeout   <= TimeoutReset;
         cfg_ff.freeze         <= 1'b0;
      end else begin
         gain_fast_ff <= gain_fast_in;
         gain_slow_ff <= gain_slow_in;
         cfg_ff       <= cfg_in;
      end
   end

   aspd_filter #(
      .SAMPLE_BITS    (SAMPLE_BITS),
      .GAIN_FRAC_BITS (GAIN_FRAC_BITS)
   ) u_filter (
      .clock             (clock),
      .reset             (reset),
      .req_valid         (req_valid),
      .req_stall         (req_stall),
      .req_sample        (req_sample),
      .req_last_in_block (req_last_in_block),
      .req_now_ms        (req_now_ms),
      .gain_fast         (gain_fast_ff),
      .gain_slow         (gain_slow_ff),
      .freeze            (cfg_ff.freeze),
      .stage_ctrl        (stage_ctrl),
      .stage_level       (stage_level),
      .stage_take        (stage_take)
   );

   aspd_detect #(
      .SAMPLE_BITS (SAMPLE_BITS)
   ) u_detect (
      .clock        (clock),
      .reset        (reset),
      .cfg          (cfg_ff),
      .stage_ctrl   (stage_ctrl),
      .stage_level  (stage_level),
      .stage_take   (stage_take),
      .rsp_valid    (rsp_valid),
      .rsp_stall    (rsp_stall),
      .rsp_level    (rsp_level),
      .rsp_detected (rsp_detected)
   );

endmodule

// ----- rtl/aspd_filter.sv -----
module aspd_filter import aspd_pkg::*; #(
   parameter int unsigned SAMPLE_BITS    = 12,
   parameter int unsigned GAIN_FRAC_BITS = 16
) (
   input  logic                   clock,
   input  logic                   reset,
   input  logic                   req_valid,
   output logic                   req_stall,
   input  logic [SAMPLE_BITS-1:0] req_sample,
   input  logic                   req_last_in_block,
   input  logic [TimeBits-1:0]    req_now_ms,
   input  logic [GainBits-1:0]    gain_fast,
   input  logic [GainBits-1:0]    gain_slow,
   input  logic                   freeze,
   output stage_ctrl_type         stage_ctrl,
   output logic [SAMPLE_BITS-1:0] stage_level,
   input  logic                   stage_take
);

   localparam int unsigned FiltBits = SAMPLE_BITS + GAIN_FRAC_BITS;
   localparam int unsigned ProdBits = FiltBits + GainBits;
   localparam int unsigned StepBits = ProdBits - GAIN_FRAC_BITS;
   localparam int unsigned SumBits  = ((FiltBits > StepBits) ? FiltBits : StepBits) + 1;
   localparam logic [FiltBits-1:0] FiltMax   = {FiltBits{1'b1}};
   localparam logic [FiltBits-1:0] DiffLimit = FiltBits'(3) << (GAIN_FRAC_BITS - 1);
   localparam logic [SAMPLE_BITS-1:0] MinSampleCode = SAMPLE_BITS'(MinSample);

   logic [FiltBits-1:0]    filter_ff, filter_in;
   logic                   hit_ff, hit_in;
   logic [SAMPLE_BITS-1:0] block_level_ff, block_level_in;
   stage_ctrl_type         stage_ff, stage_in;
   logic [SAMPLE_BITS-1:0] level_ff, level_in;

   logic                   accept;
   logic [FiltBits-1:0]    target;
   logic                   up;
   logic [FiltBits-1:0]    mag;
   logic [GainBits-1:0]    gain;
   logic [ProdBits-1:0]    product;
   logic [StepBits-1:0]    step;
   logic [SumBits-1:0]     sum;
   logic [FiltBits-1:0]    filter_new;
   logic                   qualify;

   assign req_stall = stage_ff.valid && !stage_take;
   assign accept    = req_valid && !req_stall;

   assign target  = {req_sample, {GAIN_FRAC_BITS{1'b0}}};
   assign up      = target >= filter_ff;
   assign mag     = up ? target - filter_ff : filter_ff - target;
   assign gain    = (mag > DiffLimit) ? gain_fast : gain_slow;
   assign product = ProdBits'(mag) * ProdBits'(gain);
   assign step    = product[ProdBits-1:GAIN_FRAC_BITS];
   assign sum     = SumBits'(filter_ff) + SumBits'(step);
   assign qualify = !freeze && (req_sample >= MinSampleCode);

   always_comb begin
      if (up) begin
         filter_new = (sum > SumBits'(FiltMax)) ? FiltMax : sum[FiltBits-1:0];
      end else begin
         filter_new = (SumBits'(step) > SumBits'(filter_ff)) ? '0
                    : filter_ff - FiltBits'(step);
      end
   end

   always_comb begin
      filter_in      = filter_ff;
      hit_in         = hit_ff;
      block_level_in = block_level_ff;
      stage_in       = stage_ff;
      level_in       = level_ff;
      if (stage_take) begin
         stage_in.valid = 1'b0;
      end
      if (accept) begin
         if (qualify) begin
            filter_in      = filter_new;
            hit_in         = 1'b1;
            block_level_in = filter_new[FiltBits-1:GAIN_FRAC_BITS];
         end
         stage_in.valid  = 1'b1;
         stage_in.last   = req_last_in_block;
         stage_in.now_ms = req_now_ms;
         level_in        = hit_in ? block_level_in : '0;
         if (req_last_in_block && !freeze) begin
            hit_in         = 1'b0;
            block_level_in = '0;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         filter_ff      <= '0;
         hit_ff         <= 1'b0;
         block_level_ff <= '0;
         stage_ff       <= '0;
      end else begin
         filter_ff      <= filter_in;
         hit_ff         <= hit_in;
         block_level_ff <= block_level_in;
         stage_ff       <= stage_in;
      end
   end

   always_ff @(posedge clock) begin
      level_ff <= level_in;
   end

   assign stage_ctrl  = stage_ff;
   assign stage_level = level_ff;

endmodule

// ----- rtl/aspd_detect.sv -----
module aspd_detect import aspd_pkg::*; #(
   parameter int unsigned SAMPLE_BITS = 12
) (
   input  logic                   clock,
   input  logic                   reset,
   input  det_cfg_type            cfg,
   input  stage_ctrl_type         stage_ctrl,
   input  logic [SAMPLE_BITS-1:0] stage_level,
   output logic                   stage_take,
   output logic                   rsp_valid,
   input  logic                   rsp_stall,
   output logic [SAMPLE_BITS-1:0] rsp_level,
   output logic                   rsp_detected
);

   localparam int unsigned CmpBits = (SAMPLE_BITS > ThrBits) ? SAMPLE_BITS : ThrBits;

   logic [SAMPLE_BITS-1:0] held_ff, held_in;
   logic                   det_ff, det_in;
   logic                   rise_run_ff, rise_run_in;
   logic [TimeBits-1:0]    rise_start_ff, rise_start_in;
   logic                   fall_run_ff, fall_run_in;
   logic [TimeBits-1:0]    fall_start_ff, fall_start_in;
   logic                   rsp_valid_ff, rsp_valid_in;
   logic [SAMPLE_BITS-1:0] rsp_level_ff, rsp_level_in;
   logic                   rsp_det_ff, rsp_det_in;

   logic                   out_free;
   logic                   run;
   logic [ThrBits-1:0]     thr;
   logic                   above;
   logic [TimeBits-1:0]    now;
   logic [TimeBits-1:0]    rise_eff;
   logic [TimeBits-1:0]    fall_eff;
   logic                   rise_done;
   logic                   fall_done;

   assign out_free   = !rsp_valid_ff || !rsp_stall;
   assign stage_take = stage_ctrl.valid && (!stage_ctrl.last || out_free);
   assign run        = stage_take && stage_ctrl.last;

   assign now       = stage_ctrl.now_ms;
   assign thr       = cfg.distance_min + cfg.trigger_margin;
   assign above     = CmpBits'(stage_level) > CmpBits'(thr);
   assign rise_eff  = rise_run_ff ? rise_start_ff : now;
   assign fall_eff  = fall_run_ff ? fall_start_ff : now;
   assign rise_done = (now - rise_eff) >= cfg.rise_timeout;
   assign fall_done = (now - fall_eff) >= cfg.fall_timeout;

   always_comb begin
      held_in       = held_ff;
      det_in        = det_ff;
      rise_run_in   = rise_run_ff;
      rise_start_in = rise_start_ff;
      fall_run_in   = fall_run_ff;
      fall_start_in = fall_start_ff;
      if (run && !cfg.freeze) begin
         held_in       = stage_level;
         rise_run_in   = 1'b0;
         rise_start_in = '0;
         fall_run_in   = 1'b0;
         fall_start_in = '0;
         if (above) begin
            if (!det_ff) begin
               if (rise_done) begin
                  det_in = 1'b1;
               end else begin
                  rise_run_in   = 1'b1;
                  rise_start_in = rise_eff;
               end
            end
         end else if (rise_run_ff) begin
            if (fall_done || rise_done) begin
               det_in = 1'b0;
            end else begin
               rise_run_in   = 1'b1;
               rise_start_in = rise_start_ff;
               fall_run_in   = 1'b1;
               fall_start_in = fall_eff;
            end
         end else begin
            det_in = 1'b0;
         end
      end
   end

   always_comb begin
      rsp_valid_in = rsp_valid_ff;
      rsp_level_in = rsp_level_ff;
      rsp_det_in   = rsp_det_ff;
      if (rsp_valid_ff && !rsp_stall) begin
         rsp_valid_in = 1'b0;
      end
      if (run) begin
         rsp_valid_in = 1'b1;
         rsp_level_in = held_in;
         rsp_det_in   = det_in;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         held_ff       <= '0;
         det_ff        <= 1'b0;
         rise_run_ff   <= 1'b0;
         rise_start_ff <= '0;
         fall_run_ff   <= 1'b0;
         fall_start_ff <= '0;
         rsp_valid_ff  <= 1'b0;
      end else begin
         held_ff       <= held_in;
         det_ff        <= det_in;
         rise_run_ff   <= rise_run_in;
         rise_start_ff <= rise_start_in;
         fall_run_ff   <= fall_run_in;
         fall_start_ff <= fall_start_in;
         rsp_valid_ff  <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      rsp_level_ff <= rsp_level_in;
      rsp_det_ff   <= rsp_det_in;
   end

   assign rsp_valid    = rsp_valid_ff;
   assign rsp_level    = rsp_level_ff;
   assign rsp_detected = rsp_det_ff;

endmodule
